// ===== rtl/mpa_pkg.sv =====
// Package with shared types, constants and helpers of the phase-angle dimmer.
`default_nettype none
package mpa_pkg;

    localparam int unsigned DutyWidth  = 8;
    localparam int unsigned CountWidth = 8;

    localparam logic [DutyWidth-1:0]  DutyReset   = 8'hFF;
    localparam logic [CountWidth-1:0] PeriodReset = 8'hFF;
    localparam logic [CountWidth-1:0] CountMax    = 8'hFF;
    localparam int unsigned           GuardShift  = 4;

    typedef enum logic {
        CFG_DUTY_CH0 = 1'b0,
        CFG_DUTY_CH1 = 1'b1
    } t_cfg_index;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_EDGE = 1'b1
    } t_req_type;

    typedef struct packed {
        logic                  drive_ch0;
        logic                  drive_ch1;
        logic [CountWidth-1:0] period_now;
    } t_result;

    function automatic logic [CountWidth-1:0] scale_point(
        input logic [CountWidth-1:0] period,
        input logic [DutyWidth-1:0]  duty
    );
        logic [CountWidth+DutyWidth-1:0] prod;
        prod = period * duty;
        return prod[CountWidth+DutyWidth-1:DutyWidth];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mains_phase_angle_pwm_top.sv =====
// Top level of the two-channel mains phase-angle dimmer.
// The result of an accepted beat is held in the result register, or in the skid stage.
// One beat per cycle while o_stall is low; counter and firing points register on accept.
// The output side has a result register and a skid stage, so input stalls only
// when both hold beats. Reset is synchronous and active low; duties reset to 255,
// the half period to 255, and the counter, firing points and drives to zero.
`default_nettype none
module mains_phase_angle_pwm_top
    import mpa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_index,
    input  wire logic [DutyWidth-1:0]  i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_req_type,
    input  wire logic                  i_sync_level,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_drive_ch0,
    output logic                       o_drive_ch1,
    output logic [CountWidth-1:0]      o_period_now
);

    logic    accept;
    logic    buf_full;
    t_result core_result;
    t_result out_result;

    assign o_stall = buf_full;
    assign accept  = i_valid && !buf_full;

    mpa_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_sync_level (i_sync_level),
        .o_result     (core_result)
    );

    mpa_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (core_result),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_result)
    );

    assign o_drive_ch0  = out_result.drive_ch0;
    assign o_drive_ch1  = out_result.drive_ch1;
    assign o_period_now = out_result.period_now;

endmodule
`default_nettype wire

// ===== rtl/mpa_core.sv =====
// Half-cycle counter, firing points and gate drive state of the dimmer.
`default_nettype none
module mpa_core
    import mpa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_index,
    input  wire logic [DutyWidth-1:0] i_cfg_data,
    input  wire logic                 i_accept,
    input  wire logic                 i_req_type,
    input  wire logic                 i_sync_level,
    output t_result                   o_result
);

    logic [DutyWidth-1:0]  r_duty0, r_duty1;
    logic                  r_running, n_running;
    logic [CountWidth-1:0] r_tick_count, n_tick_count;
    logic [CountWidth-1:0] r_half_period, n_half_period;
    logic [CountWidth-1:0] r_fire0, n_fire0;
    logic [CountWidth-1:0] r_fire1, n_fire1;
    logic [1:0]            r_drive, n_drive;
    logic [CountWidth-1:0] count_inc;
    logic                  edge_ends;

    assign count_inc = r_tick_count + 1'b1;
    assign edge_ends = r_running && i_sync_level
                       && (r_tick_count > (r_half_period >> GuardShift));

    always_comb begin
        n_running     = r_running;
        n_tick_count  = r_tick_count;
        n_half_period = r_half_period;
        n_fire0       = r_fire0;
        n_fire1       = r_fire1;
        n_drive       = r_drive;
        if (i_req_type == REQ_EDGE) begin
            if (edge_ends) begin
                n_half_period = r_tick_count;
                n_running     = 1'b0;
                n_tick_count  = '0;
                n_drive       = '0;
            end else begin
                n_running = 1'b1;
                n_fire0   = scale_point(r_half_period, r_duty0);
                n_fire1   = scale_point(r_half_period, r_duty1);
            end
        end else if (r_running) begin
            if (r_tick_count == CountMax) begin
                n_running    = 1'b0;
                n_tick_count = '0;
                n_drive      = '0;
            end else begin
                n_tick_count = count_inc;
                if (count_inc == r_fire0) begin
                    n_drive[0] = 1'b1;
                end
                if (count_inc == r_fire1) begin
                    n_drive[1] = 1'b1;
                end
            end
        end
    end

    assign o_result.drive_ch0  = n_drive[0];
    assign o_result.drive_ch1  = n_drive[1];
    assign o_result.period_now = n_half_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty0 <= DutyReset;
            r_duty1 <= DutyReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DUTY_CH0: r_duty0 <= i_cfg_data;
                CFG_DUTY_CH1: r_duty1 <= i_cfg_data;
                default:      r_duty0 <= r_duty0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_tick_count  <= '0;
            r_half_period <= PeriodReset;
            r_fire0       <= '0;
            r_fire1       <= '0;
            r_drive       <= '0;
        end else if (i_accept) begin
            r_running     <= n_running;
            r_tick_count  <= n_tick_count;
            r_half_period <= n_half_period;
            r_fire0       <= n_fire0;
            r_fire1       <= n_fire1;
            r_drive       <= n_drive;
        end
    end

    a_stopped_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_tick_count == '0))
        else $error("Counter is nonzero while stopped.");

    a_stopped_drives_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_drive == '0))
        else $error("Gate drive is on while the counter is stopped.");

    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_req_type == REQ_TICK && r_running && r_tick_count != CountMax)
        |=> (r_tick_count == $past(r_tick_count) + 8'd1))
        else $error("Running counter did not advance on a tick.");

endmodule
`default_nettype wire

// ===== rtl/mpa_out_buf.sv =====
// Result register with a skid stage on the output channel.
`default_nettype none
module mpa_out_buf
    import mpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_result   i_data,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_result   o_data
);

    logic    r_main_valid, r_skid_valid;
    t_result r_main, r_skid;
    logic    pop;

    assign pop     = r_main_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_main <= r_skid;
        end else if (i_push && (pop || !r_main_valid)) begin
            r_main <= i_data;
        end
        if (i_push && r_main_valid && !pop) begin
            r_skid <= i_data;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("Skid stage holds a beat while the result register is empty.");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("Beat pushed into a full output buffer.");

    a_stalled_beat_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_valid && i_stall) |=> (r_main_valid && $stable(r_main)))
        else $error("Stalled result beat changed or was dropped.");

endmodule
`default_nettype wire
